// ===== rtl/core/sfd_pkg.sv =====
`default_nettype none

package sfd_pkg;

	localparam int CRC_W      = 16;
	localparam int BYTE_W     = 8;
	localparam int LEN_W      = 11;
	localparam int OUT_CNT_W  = 32;
	localparam int CFG_IDX_W  = 2;

	localparam int COUNTER_BITS_DEF = 32;

	localparam logic [BYTE_W-1:0] START_MARK     = 8'hF0;
	localparam logic [BYTE_W-1:0] TYPE_DATA      = 8'h00;
	localparam logic [BYTE_W-1:0] TYPE_COMMAND   = 8'h01;
	localparam logic [BYTE_W-1:0] TYPE_RESPONSE  = 8'h81;
	localparam logic [BYTE_W-1:0] LEN_HIGH_LIMIT = 8'h05;

	localparam logic [CRC_W-1:0] CRC_POLY_RST = 16'hA001;
	localparam logic [CRC_W-1:0] CRC_INIT_RST = 16'hFFFF;
	localparam logic [LEN_W-1:0] MAX_LEN_RST  = 11'd1514;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CRC_POLY = 2'd0,
		REG_CRC_INIT = 2'd1,
		REG_MAX_LEN  = 2'd2,
		REG_NONE     = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_OK      = 2'd1,
		KIND_CRC_ERR = 2'd2,
		KIND_ABORT   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		FT_DATA     = 2'd0,
		FT_COMMAND  = 2'd1,
		FT_RESPONSE = 2'd2
	} ftype_t;

endpackage

`default_nettype wire

// ===== rtl/core/sfd_crc8.sv =====
`default_nettype none

// one byte through a reflected CRC-16, LSB first
module sfd_crc8
	import sfd_pkg::*;
(
	input  wire logic [CRC_W-1:0]  crc_in,
	input  wire logic [CRC_W-1:0]  poly,
	input  wire logic [BYTE_W-1:0] data,
	output logic      [CRC_W-1:0]  crc_out
);

	always_comb begin
		logic [CRC_W-1:0] c;
		c = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, data};
		for (int i = 0; i < BYTE_W; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ poly;
			end else begin
				c = c >> 1;
			end
		end
		crc_out = c;
	end

endmodule

`default_nettype wire

// ===== rtl/core/serial_frame_deframer_crc16.sv =====
`default_nettype none

// channel   dir  handshake             payload
// s_*       in   s_tvalid/s_tready     tdata: rx_byte; tuser: action
// m_*       out  m_tvalid/m_tready     tdata: payload_byte, frame_type, frame_length,
//                                      good_frames, bad_frames; tuser: kind;
//                                      tlast: end_of_frame
// cfg_*     in   cfg_we                cfg_index, cfg_data
//
// One request per cycle sustained while the result register is not stalled: input register, one pass of parse and
// byte-wide CRC logic, then the result register.
// An accepted request is held in the input register; its result is registered once the output is free.
// arst_n clears phase, held fields, counters and valid flags, and sets the config registers to their defaults.
// A stalled result register holds the input stage; s_tready drops only then.
module serial_frame_deframer_crc16
	import sfd_pkg::*;
#(
	parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,

	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [7:0]            s_tdata,   // [7:0] rx_byte
	input  wire logic                  s_tuser,   // [0] action

	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [87:0]                m_tdata,   // [7:0] payload_byte, [9:8] frame_type,
	                                              // [20:10] frame_length,
	                                              // [52:21] good_frames,
	                                              // [84:53] bad_frames, [87:85] zero
	output logic [1:0]                 m_tuser,   // [1:0] kind
	output logic                       m_tlast,   // end_of_frame

	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CRC_W-1:0]      cfg_data
);

	typedef enum logic [2:0] {
		PH_HUNT, PH_TYPE, PH_LEN_HI, PH_LEN_LO, PH_PAYLOAD, PH_CRC_LO, PH_CRC_HI
	} phase_t;

	logic [CRC_W-1:0]        poly_q, init_q;
	logic [LEN_W-1:0]        max_len_q;

	logic                    valid_s1, action_s1;
	logic [BYTE_W-1:0]       byte_s1;

	phase_t                  phase_q, phase_d;
	ftype_t                  type_q, type_d;
	logic [LEN_W-1:0]        len_q, len_d, len_lo;
	logic [LEN_W-1:0]        taken_q, taken_d, taken_inc;
	logic [CRC_W-1:0]        crc_q, crc_d, crc_src, crc_new;
	logic [BYTE_W-1:0]       crc_lo_q, crc_lo_d;
	logic [COUNTER_BITS-1:0] good_q, good_d, bad_q, bad_d;

	logic                    adv, emit;
	kind_t                   kind_d;
	logic [BYTE_W-1:0]       pbyte_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q    <= CRC_POLY_RST;
			init_q    <= CRC_INIT_RST;
			max_len_q <= MAX_LEN_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_CRC_POLY: poly_q    <= cfg_data;
				REG_CRC_INIT: init_q    <= cfg_data;
				REG_MAX_LEN:  max_len_q <= cfg_data[LEN_W-1:0];
				REG_NONE:     ;
				default:      ;
			endcase
		end
	end

	assign adv      = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			action_s1 <= s_tuser;
			byte_s1   <= s_tdata;
		end
	end

	assign crc_src = (phase_q == PH_HUNT) ? init_q : crc_q;

	sfd_crc8 u_crc (
		.crc_in  (crc_src),
		.poly    (poly_q),
		.data    (byte_s1),
		.crc_out (crc_new)
	);

	assign len_lo    = len_q | {{(LEN_W-BYTE_W){1'b0}}, byte_s1};
	assign taken_inc = taken_q + 1'b1;

	always_comb begin
		phase_d  = phase_q;
		type_d   = type_q;
		len_d    = len_q;
		taken_d  = taken_q;
		crc_d    = crc_q;
		crc_lo_d = crc_lo_q;
		good_d   = good_q;
		bad_d    = bad_q;
		emit     = 1'b0;
		kind_d   = KIND_PAYLOAD;
		pbyte_d  = '0;
		if (action_s1) begin
			if (phase_q != PH_HUNT) begin
				emit    = 1'b1;
				kind_d  = KIND_ABORT;
				phase_d = PH_HUNT;
			end
		end else begin
			unique case (phase_q)
				PH_HUNT: begin
					if (byte_s1 == START_MARK) begin
						phase_d  = PH_TYPE;
						type_d   = FT_DATA;
						len_d    = '0;
						taken_d  = '0;
						crc_lo_d = '0;
						crc_d    = crc_new;
					end
				end
				PH_TYPE: begin
					phase_d = PH_LEN_HI;
					crc_d   = crc_new;
					priority if (byte_s1 == TYPE_DATA) begin
						type_d = FT_DATA;
					end else if (byte_s1 == TYPE_COMMAND) begin
						type_d = FT_COMMAND;
					end else if (byte_s1 == TYPE_RESPONSE) begin
						type_d = FT_RESPONSE;
					end else begin
						phase_d = PH_HUNT;
						crc_d   = crc_q;
					end
				end
				PH_LEN_HI: begin
					if (byte_s1 > LEN_HIGH_LIMIT) begin
						phase_d = PH_HUNT;
					end else begin
						len_d   = {byte_s1[LEN_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
						crc_d   = crc_new;
						phase_d = PH_LEN_LO;
					end
				end
				PH_LEN_LO: begin
					len_d = len_lo;
					if (len_lo > max_len_q) begin
						phase_d = PH_HUNT;
					end else begin
						crc_d   = crc_new;
						taken_d = '0;
						phase_d = (len_lo == '0) ? PH_CRC_LO : PH_PAYLOAD;
					end
				end
				PH_PAYLOAD: begin
					crc_d   = crc_new;
					taken_d = taken_inc;
					if (taken_inc >= len_q) begin
						phase_d = PH_CRC_LO;
					end
					emit    = 1'b1;
					kind_d  = KIND_PAYLOAD;
					pbyte_d = byte_s1;
				end
				PH_CRC_LO: begin
					crc_lo_d = byte_s1;
					phase_d  = PH_CRC_HI;
				end
				PH_CRC_HI: begin
					phase_d = PH_HUNT;
					emit    = 1'b1;
					if ({byte_s1, crc_lo_q} == crc_q) begin
						good_d = good_q + 1'b1;
						kind_d = KIND_OK;
					end else begin
						bad_d  = bad_q + 1'b1;
						kind_d = KIND_CRC_ERR;
					end
				end
				default: phase_d = PH_HUNT;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			type_q   <= FT_DATA;
			len_q    <= '0;
			taken_q  <= '0;
			crc_q    <= '0;
			crc_lo_q <= '0;
			good_q   <= '0;
			bad_q    <= '0;
			m_tvalid <= 1'b0;
		end else begin
			if (adv) begin
				phase_q  <= phase_d;
				type_q   <= type_d;
				len_q    <= len_d;
				taken_q  <= taken_d;
				crc_q    <= crc_d;
				crc_lo_q <= crc_lo_d;
				good_q   <= good_d;
				bad_q    <= bad_d;
				m_tvalid <= emit;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			m_tdata <= {3'b000, OUT_CNT_W'(bad_d), OUT_CNT_W'(good_d),
			            len_d, type_d, pbyte_d};
			m_tuser <= kind_d;
			m_tlast <= (kind_d != KIND_PAYLOAD);
		end
	end

	a_last_matches_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tuser != KIND_PAYLOAD)))
		else $error("tlast disagrees with kind");

	a_timeout_hunts: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && action_s1) |=> (phase_q == PH_HUNT))
		else $error("timeout did not return to hunting");

	a_good_step: assert property (@(posedge clk) disable iff (!arst_n)
		(good_q != $past(good_q)) |-> (good_q == $past(good_q) + 1'b1))
		else $error("good frame count jumped");

	a_one_count: assert property (@(posedge clk) disable iff (!arst_n)
		!((good_q != $past(good_q)) && (bad_q != $past(bad_q))))
		else $error("both frame counts moved");

endmodule

`default_nettype wire

// ===== dv/serial_frame_deframer_crc16_tb.sv =====
`default_nettype none

module serial_frame_deframer_crc16_tb;
	import sfd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int HOLD_CYCLES = 80;
	localparam int N_DIR = 29;

	typedef enum logic [2:0] {
		ST_HUNT, ST_TYPE, ST_LEN_HI, ST_LEN_LO, ST_PAYLOAD, ST_CRC_LO, ST_CRC_HI
	} parse_phase_t;

	// which byte a directed row sends
	typedef enum logic [1:0] {
		PICK_RAW, PICK_CRC_LO, PICK_CRC_HI, PICK_CRC_BAD
	} pick_t;

	// where a directed row gets its expectation
	typedef enum logic [1:0] {
		SRC_MODEL, SRC_NONE, SRC_TYPED
	} src_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  pbyte;
		ftype_t      ftype;
		logic [10:0] flen;
		logic        eof;
		logic [31:0] good;
		logic [31:0] bad;
	} frame_res_t;

	typedef struct packed {
		logic       act;
		logic [7:0] data;
		pick_t      pick;
		src_t       src;
		frame_res_t res;
	} stim_row_t;

	localparam frame_res_t NO_RES = '0;
	localparam frame_res_t ABORT_TYPE = '{KIND_ABORT, 8'h00, FT_DATA, 11'd0, 1'b1, 32'd0, 32'd0};
	localparam frame_res_t ABORT_LEN =
		'{KIND_ABORT, 8'h00, FT_RESPONSE, 11'h500, 1'b1, 32'd0, 32'd0};

	localparam stim_row_t DIR_ROWS [N_DIR] = '{
		// bad type byte 0xF0 must not restart the hunt
		'{1'b0, 8'hF0, PICK_RAW, SRC_NONE, NO_RES},
		'{1'b0, 8'hF0, PICK_RAW, SRC_NONE, NO_RES},
		'{1'b0, 8'h00, PICK_RAW, SRC_NONE, NO_RES},
		'{1'b0, 8'h00, PICK_RAW, SRC_NONE, NO_RES},
		'{1'b0, 8'h00, PICK_RAW, SRC_NONE, NO_RES},
		'{1'b1, 8'hFF, PICK_RAW, SRC_NONE, NO_RES},
		// timeout in the type phase
		'{1'b0, 8'hF0, PICK_RAW, SRC_NONE, NO_RES},
		'{1'b1, 8'h00, PICK_RAW, SRC_TYPED, ABORT_TYPE},
		// timeout after the high length byte
		'{1'b0, 8'hF0, PICK_RAW, SRC_NONE, NO_RES},
		'{1'b0, 8'h81, PICK_RAW, SRC_NONE, NO_RES},
		'{1'b0, 8'h05, PICK_RAW, SRC_NONE, NO_RES},
		'{1'b1, 8'h5A, PICK_RAW, SRC_TYPED, ABORT_LEN},
		// length one above the default limit
		'{1'b0, 8'hF0, PICK_RAW, SRC_NONE, NO_RES},
		'{1'b0, 8'h01, PICK_RAW, SRC_NONE, NO_RES},
		'{1'b0, 8'h05, PICK_RAW, SRC_NONE, NO_RES},
		'{1'b0, 8'hEB, PICK_RAW, SRC_NONE, NO_RES},
		// zero length, good crc
		'{1'b0, 8'hF0, PICK_RAW, SRC_NONE, NO_RES},
		'{1'b0, 8'h00, PICK_RAW, SRC_NONE, NO_RES},
		'{1'b0, 8'h00, PICK_RAW, SRC_NONE, NO_RES},
		'{1'b0, 8'h00, PICK_RAW, SRC_NONE, NO_RES},
		'{1'b0, 8'h00, PICK_CRC_LO, SRC_NONE, NO_RES},
		'{1'b0, 8'h00, PICK_CRC_HI, SRC_MODEL, NO_RES},
		// one payload byte, bad crc
		'{1'b0, 8'hF0, PICK_RAW, SRC_NONE, NO_RES},
		'{1'b0, 8'h81, PICK_RAW, SRC_NONE, NO_RES},
		'{1'b0, 8'h00, PICK_RAW, SRC_NONE, NO_RES},
		'{1'b0, 8'h01, PICK_RAW, SRC_NONE, NO_RES},
		'{1'b0, 8'hFF, PICK_RAW, SRC_MODEL, NO_RES},
		'{1'b0, 8'h00, PICK_CRC_LO, SRC_NONE, NO_RES},
		'{1'b0, 8'h00, PICK_CRC_BAD, SRC_MODEL, NO_RES}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [7:0]           s_tdata = 8'h00;
	logic                 s_tuser = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [87:0]          m_tdata;
	logic [1:0]           m_tuser;
	logic                 m_tlast;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_CRC_POLY;
	logic [CRC_W-1:0]     cfg_data = '0;

	serial_frame_deframer_crc16 dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	// predictor state and register copies
	parse_phase_t pr_phase = ST_HUNT;
	ftype_t       pr_type = FT_DATA;
	logic [10:0]  pr_len = '0;
	logic [10:0]  pr_taken = '0;
	logic [15:0]  pr_crc = '0;
	logic [7:0]   pr_crc_lo = '0;
	logic [31:0]  pr_good = '0;
	logic [31:0]  pr_bad = '0;
	logic [15:0]  cfg_poly = CRC_POLY_RST;
	logic [15:0]  cfg_init = CRC_INIT_RST;
	logic [10:0]  cfg_maxlen = MAX_LEN_RST;

	frame_res_t deframe_expect_q[$];

	int  n_items = 0;
	int  n_err = 0;
	int  n_payload = 0;
	int  n_ok = 0;
	int  n_crc_err = 0;
	int  n_abort = 0;
	bit  gap_on = 1'b1;
	bit  calm = 1'b0;
	bit  hold_go = 1'b0;
	bit  rx_stall_on = 1'b1;

	function automatic logic [15:0] crc16_refl_byte(input logic [15:0] c, input logic [7:0] b,
			input logic [15:0] poly);
		logic [15:0] r;
		r = c ^ {8'h00, b};
		for (int k = 0; k < 8; k++)
			r = r[0] ? ((r >> 1) ^ poly) : (r >> 1);
		return r;
	endfunction

	function automatic frame_res_t deframe_res(input kind_t k, input logic [7:0] b, input logic eof);
		return '{k, b, pr_type, pr_len, eof, pr_good, pr_bad};
	endfunction

	// returns 1 when the request yields a result; idle marks a request the block ignores
	function automatic bit deframe_predict(input logic act, input logic [7:0] b,
			output frame_res_t r, output bit idle);
		logic [10:0] l;
		r = NO_RES;
		idle = 1'b0;
		if (act) begin
			if (pr_phase == ST_HUNT) begin
				idle = 1'b1;
				return 1'b0;
			end
			r = deframe_res(KIND_ABORT, 8'h00, 1'b1);
			pr_phase = ST_HUNT;
			return 1'b1;
		end
		case (pr_phase)
			ST_HUNT: begin
				if (b == START_MARK) begin
					pr_phase = ST_TYPE;
					pr_type = FT_DATA;
					pr_len = '0;
					pr_taken = '0;
					pr_crc_lo = '0;
					pr_crc = crc16_refl_byte(cfg_init, b, cfg_poly);
				end else begin
					idle = 1'b1;
				end
			end
			ST_TYPE: begin
				if (b == TYPE_DATA)
					pr_type = FT_DATA;
				else if (b == TYPE_COMMAND)
					pr_type = FT_COMMAND;
				else if (b == TYPE_RESPONSE)
					pr_type = FT_RESPONSE;
				else begin
					pr_phase = ST_HUNT;
					return 1'b0;
				end
				pr_crc = crc16_refl_byte(pr_crc, b, cfg_poly);
				pr_phase = ST_LEN_HI;
			end
			ST_LEN_HI: begin
				if (b > LEN_HIGH_LIMIT) begin
					pr_phase = ST_HUNT;
					return 1'b0;
				end
				pr_len = {b[2:0], 8'h00};
				pr_crc = crc16_refl_byte(pr_crc, b, cfg_poly);
				pr_phase = ST_LEN_LO;
			end
			ST_LEN_LO: begin
				l = pr_len | {3'b000, b};
				pr_len = l;
				if (l > cfg_maxlen) begin
					pr_phase = ST_HUNT;
					return 1'b0;
				end
				pr_crc = crc16_refl_byte(pr_crc, b, cfg_poly);
				pr_taken = '0;
				pr_phase = (l == 0) ? ST_CRC_LO : ST_PAYLOAD;
			end
			ST_PAYLOAD: begin
				pr_crc = crc16_refl_byte(pr_crc, b, cfg_poly);
				pr_taken = pr_taken + 11'd1;
				if (pr_taken >= pr_len)
					pr_phase = ST_CRC_LO;
				r = deframe_res(KIND_PAYLOAD, b, 1'b0);
				return 1'b1;
			end
			ST_CRC_LO: begin
				pr_crc_lo = b;
				pr_phase = ST_CRC_HI;
			end
			ST_CRC_HI: begin
				pr_phase = ST_HUNT;
				if ({b, pr_crc_lo} == pr_crc) begin
					pr_good = pr_good + 32'd1;
					r = deframe_res(KIND_OK, 8'h00, 1'b1);
				end else begin
					pr_bad = pr_bad + 32'd1;
					r = deframe_res(KIND_CRC_ERR, 8'h00, 1'b1);
				end
				return 1'b1;
			end
			default: pr_phase = ST_HUNT;
		endcase
		return 1'b0;
	endfunction

	function automatic logic [7:0] rand_type_code();
		case ($urandom_range(0, 2))
			0: return TYPE_DATA;
			1: return TYPE_COMMAND;
			default: return TYPE_RESPONSE;
		endcase
	endfunction

	task automatic push_req(input logic act, input logic [7:0] b, input src_t src,
			input frame_res_t typed);
		frame_res_t r;
		bit hit;
		bit idle;
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		hit = deframe_predict(act, b, r, idle);
		if (!idle)
			n_items++;
		case (src)
			SRC_MODEL: if (hit) deframe_expect_q.push_back(r);
			SRC_TYPED: deframe_expect_q.push_back(typed);
			default: ;
		endcase
		if (gap_on && !calm && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
	endtask

	// cut > 0: send only the first cut bytes, then a timeout
	task automatic send_frame(input int len, input bit corrupt, input int cut);
		logic [7:0] fb[$];
		logic [15:0] c;
		fb = {START_MARK, rand_type_code(), 8'(len >> 8), 8'(len)};
		repeat (len) fb.push_back(8'($urandom));
		c = cfg_init;
		foreach (fb[i])
			c = crc16_refl_byte(c, fb[i], cfg_poly);
		if (corrupt)
			c ^= 16'($urandom_range(1, 16'hFFFF));
		fb.push_back(c[7:0]);
		fb.push_back(c[15:8]);
		if (cut > 0 && cut < fb.size())
			fb = fb[0:cut-1];
		foreach (fb[i])
			push_req(1'b0, fb[i], SRC_MODEL, NO_RES);
		if (cut > 0)
			push_req(1'b1, 8'($urandom), SRC_MODEL, NO_RES);
	endtask

	task automatic rand_scenario();
		int pick;
		int len;
		int mx;
		logic [7:0] b;
		mx = cfg_maxlen;
		pick = $urandom_range(0, 99);
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 12);
		if (mx <= 64 && $urandom_range(0, 15) == 0)
			len = mx;
		if (len > mx)
			len = mx;
		gap_on = $urandom_range(0, 1);
		if (pick < 60) begin
			send_frame(len, $urandom_range(0, 4) == 0, 0);
		end else if (pick < 72) begin
			send_frame(len, 1'b0, $urandom_range(1, len + 5));
		end else if (pick < 84) begin
			push_req(1'b0, START_MARK, SRC_MODEL, NO_RES);
			case ($urandom_range(0, 2))
				0: begin
					do b = 8'($urandom);
					while (b == TYPE_DATA || b == TYPE_COMMAND || b == TYPE_RESPONSE);
					push_req(1'b0, b, SRC_MODEL, NO_RES);
				end
				1: begin
					push_req(1'b0, rand_type_code(), SRC_MODEL, NO_RES);
					push_req(1'b0, 8'($urandom_range(6, 255)), SRC_MODEL, NO_RES);
				end
				default: begin
					push_req(1'b0, rand_type_code(), SRC_MODEL, NO_RES);
					if (mx < 1535) begin
						len = $urandom_range(mx + 1, 1535);
						push_req(1'b0, 8'(len >> 8), SRC_MODEL, NO_RES);
						push_req(1'b0, 8'(len), SRC_MODEL, NO_RES);
					end else begin
						push_req(1'b0, 8'($urandom_range(6, 255)), SRC_MODEL, NO_RES);
					end
				end
			endcase
		end else if (pick < 95) begin
			repeat ($urandom_range(1, 6))
				push_req($urandom_range(0, 4) == 0, 8'($urandom), SRC_MODEL, NO_RES);
		end else begin
			push_req(1'b1, 8'($urandom), SRC_MODEL, NO_RES);
		end
	endtask

	task automatic run_until(input int target);
		while (n_items < target)
			rand_scenario();
	endtask

	task automatic cfg_write(input cfg_reg_t idx, input logic [15:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		case (idx)
			REG_CRC_POLY: cfg_poly = v;
			REG_CRC_INIT: cfg_init = v;
			REG_MAX_LEN: cfg_maxlen = v[10:0];
			default: ;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// header bytes yield nothing, so the pipe may still be busy once the queue is empty
	task automatic settle();
		s_tvalid <= 1'b0;
		while (deframe_expect_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			n_err++;
		end
	endfunction

	always @(posedge clk) begin
		frame_res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			case (m_tuser)
				KIND_PAYLOAD: n_payload++;
				KIND_OK: n_ok++;
				KIND_CRC_ERR: n_crc_err++;
				default: n_abort++;
			endcase
			if (deframe_expect_q.size() == 0) begin
				$error("unexpected result: kind %0d, byte %0h", m_tuser, m_tdata[7:0]);
				n_err++;
			end else begin
				want = deframe_expect_q.pop_front();
				check_field("kind", want.kind, m_tuser);
				check_field("payload_byte", want.pbyte, m_tdata[7:0]);
				check_field("frame_type", want.ftype, m_tdata[9:8]);
				check_field("frame_length", want.flen, m_tdata[20:10]);
				check_field("end_of_frame", want.eof, m_tlast);
				check_field("good_frames", want.good, m_tdata[52:21]);
				check_field("bad_frames", want.bad, m_tdata[84:53]);
			end
		end
	end

	// receiver: random stall bursts, one long hold-off on request
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 39) == 0)
				rx_stall_on = !rx_stall_on;
			if (hold_go) begin
				hold_go = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				m_tready <= 1'b1;
			end else if (!calm && rx_stall_on && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		logic [7:0] b;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIR; i++) begin
			case (DIR_ROWS[i].pick)
				PICK_CRC_LO: b = pr_crc[7:0];
				PICK_CRC_HI: b = pr_crc[15:8];
				PICK_CRC_BAD: b = pr_crc[15:8] ^ 8'h80;
				default: b = DIR_ROWS[i].data;
			endcase
			push_req(DIR_ROWS[i].act, b, DIR_ROWS[i].src, DIR_ROWS[i].res);
		end

		// reset register values
		run_until(130);
		hold_go = 1'b1;
		gap_on = 1'b0;
		send_frame(40, 1'b0, 0);
		run_until(250);

		settle();
		cfg_write(REG_CRC_POLY, 16'($urandom));
		cfg_write(REG_CRC_INIT, 16'($urandom));
		cfg_write(REG_MAX_LEN, 16'($urandom_range(1, 40)));
		cfg_write(REG_NONE, 16'h0000);
		run_until(450);

		settle();
		cfg_write(REG_CRC_POLY, 16'h0000);
		cfg_write(REG_CRC_INIT, 16'h0000);
		cfg_write(REG_MAX_LEN, 16'h0000);
		run_until(570);

		settle();
		cfg_write(REG_CRC_POLY, 16'hFFFF);
		cfg_write(REG_CRC_INIT, 16'hFFFF);
		cfg_write(REG_MAX_LEN, 16'hFFFF);
		run_until(730);

		settle();
		cfg_write(REG_CRC_POLY, 16'($urandom));
		cfg_write(REG_CRC_INIT, 16'($urandom));
		cfg_write(REG_MAX_LEN, 16'd1535);
		calm = 1'b1;
		run_until(900);

		settle();
		$display("%0d requests over 5 register settings: %0d payload bytes, %0d good frames,",
			n_items, n_payload, n_ok);
		$display("%0d crc errors, %0d timeout aborts, %0d mismatches", n_crc_err, n_abort, n_err);
		if (n_err == 0 && deframe_expect_q.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/core/sfd_pkg.sv
rtl/core/sfd_crc8.sv
rtl/core/serial_frame_deframer_crc16.sv
dv/serial_frame_deframer_crc16_tb.sv
